@@ design/dlc_pkg.sv @@
package dlc_pkg;

	localparam int unsigned DLC_EXP_DEPTH = 256;
	localparam logic [63:0] LN2_Q32       = 64'd2977044472;
	localparam logic [16:0] LOG2E_Q16     = 17'd94548;
	localparam int unsigned LVL_W         = 16;
	localparam int unsigned ONE_Q16       = 65536;
	// register indexes
	localparam logic [2:0] REG_MIN   = 3'd0;
	localparam logic [2:0] REG_MAX   = 3'd1;
	localparam logic [2:0] REG_START = 3'd2;
	localparam logic [2:0] REG_RISE  = 3'd3;
	localparam logic [2:0] REG_END   = 3'd4;
	localparam logic [2:0] REG_FALL  = 3'd5;
	// edge unit: diff, multiply, log2 scale, table, denominator, 17 quotient bits, select
	localparam int unsigned DIV_STEPS = 17;
	localparam int unsigned EDGE_LAT  = 5 + DIV_STEPS + 1;

	typedef logic [16:0] logit_t;

	// exp(-x) in Q.16, x in Q.32, Taylor series through the x^20 term, rounded half up
	function automatic logic [16:0] exp_entry(input logic [63:0] x);
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] rnd;
		term = 64'd1 << 32;
		sum  = 64'd1 << 32;
		for (int n = 1; n <= 20; n++) begin
			term = ((term * x) >> 32) / 64'(n);
			if (n % 2 == 1)
				sum = sum - term;
			else
				sum = sum + term;
		end
		rnd = (sum + 64'd32768) >> 16;
		return rnd[16:0];
	endfunction

endpackage

@@ design/dlc_edge.sv @@
module dlc_edge #(
	parameter int unsigned EXP_TABLE_DEPTH = dlc_pkg::DLC_EXP_DEPTH
) (
	input  logic             clk,
	input  logic             en,
	input  logic [15:0]      sample_time,
	input  logic [15:0]      mid,
	input  logic [15:0]      rate,
	output dlc_pkg::logit_t  logit
);
	import dlc_pkg::*;

	localparam int unsigned IDX_W = $clog2(EXP_TABLE_DEPTH);
	localparam int unsigned FP_W  = 16 + IDX_W + 1;

	// stage 1: signed distance from midpoint
	logic signed [16:0] diff_s1;
	logic [15:0]        rate_s1;
	// stage 2: argument a in Q.16
	logic signed [33:0] arg_s2;
	// stage 3: magnitude scaled by log2(e)
	logic [32:0]        z_s3;
	logic               pos_s3;
	// stage 4: table entry and shift
	logic [16:0]        ent_s4;
	logic [4:0]         sh_s4;
	logic               zero_s4;
	logic               pos_s4;
	// stage 5: denominator
	logic [17:0]        den_s5;
	logic               pos_s5;

	logic [16:0] tab [EXP_TABLE_DEPTH];

	for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_tab
		localparam logic [63:0] XG = (64'(g) * LN2_Q32) / 64'(EXP_TABLE_DEPTH);
		assign tab[g] = exp_entry(XG);
	end

	logic [31:0]      mag;
	logic [49:0]      zfull;
	logic [15:0]      frac;
	logic [16:0]      kint;
	logic [FP_W-1:0]  fprod;
	logic [IDX_W-1:0] idx;

	always_comb begin
		mag   = arg_s2[33] ? 32'(-arg_s2) : arg_s2[31:0];
		zfull = 50'(mag) * 50'(LOG2E_Q16);
		frac  = z_s3[15:0];
		kint  = z_s3[32:16];
		fprod = FP_W'(frac) * FP_W'(EXP_TABLE_DEPTH);
		idx   = fprod[16 +: IDX_W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1 <= $signed({1'b0, sample_time}) - $signed({1'b0, mid});
			rate_s1 <= rate;
			arg_s2  <= diff_s1 * $signed({1'b0, rate_s1});
			z_s3    <= zfull[48:16];
			pos_s3  <= !arg_s2[33];
			ent_s4  <= tab[idx];
			sh_s4   <= kint[4:0];
			zero_s4 <= kint >= 17'd17;
			pos_s4  <= pos_s3;
			den_s5  <= zero_s4 ? 18'(ONE_Q16) : 18'(ONE_Q16) + 18'(ent_s4 >> sh_s4);
			pos_s5  <= pos_s4;
		end
	end

	// restoring division, one quotient bit a stage, msb first
	logic [33:0] rem_d [DIV_STEPS];
	logic [17:0] den_d [DIV_STEPS];
	logic [16:0] quo_d [DIV_STEPS];
	logic        pos_d [DIV_STEPS];

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		localparam int unsigned J = DIV_STEPS - 1 - i;
		logic [33:0] rem_in;
		logic [17:0] den_in;
		logic [16:0] quo_in;
		logic        pos_in;
		logic [33:0] dsh;
		logic        ge;
		if (i == 0) begin : g_head
			// numerator carries the half-divisor for rounding
			assign rem_in = (34'd1 << 32) + 34'(den_s5 >> 1);
			assign den_in = den_s5;
			assign quo_in = '0;
			assign pos_in = pos_s5;
		end else begin : g_link
			assign rem_in = rem_d[i-1];
			assign den_in = den_d[i-1];
			assign quo_in = quo_d[i-1];
			assign pos_in = pos_d[i-1];
		end
		assign dsh = 34'(den_in) << J;
		assign ge  = rem_in >= dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_d[i] <= ge ? rem_in - dsh : rem_in;
				quo_d[i] <= quo_in | (17'(ge) << J);
				den_d[i] <= den_in;
				pos_d[i] <= pos_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			logit <= pos_d[DIV_STEPS-1] ? quo_d[DIV_STEPS-1] :
				17'(ONE_Q16) - quo_d[DIV_STEPS-1];
		end
	end

endmodule

@@ design/double_logistic_curve_eval.sv @@
// Double logistic seasonal curve: each sample_time item yields one result,
// curve_value = min + (max - min) * (L(rise*(t-start)) - L(fall*(t-end))),
// saturated to signed Q2.14, with params_invalid set when season_end is
// before season_start. Fully pipelined: one item per cycle unless a result
// waits unclaimed at the output. Each edge unit, whose 17-stage quotient
// chain dominates its depth, is followed by subtract, multiply and output
// stages. The whole pipe advances together; it holds while a result waits
// at the output. Write the six registers (index 0..5) only while idle.
module double_logistic_curve_eval #(
	parameter int unsigned EXP_TABLE_DEPTH = dlc_pkg::DLC_EXP_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] sample_time,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [15:0] curve_value,
	output logic        params_invalid
);
	import dlc_pkg::*;

	localparam int unsigned LAT = EDGE_LAT + 3;

	logic [15:0] min_q, max_q, start_q, rise_q, end_q, fall_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= 16'd0;
			max_q   <= 16'd16384;
			start_q <= 16'd0;
			rise_q  <= 16'd410;
			end_q   <= 16'd0;
			fall_q  <= 16'd410;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MIN:   min_q   <= cfg_data;
				REG_MAX:   max_q   <= cfg_data;
				REG_START: start_q <= cfg_data;
				REG_RISE:  rise_q  <= cfg_data;
				REG_END:   end_q   <= cfg_data;
				REG_FALL:  fall_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipe moves unless a result sits unclaimed at the output
	logic en;
	logic [LAT-1:0] vld_q;

	assign en        = !vld_q[LAT-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAT-2:0], in_valid};
	end

	logit_t l_rise, l_fall;

	dlc_edge #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_rise (
		.clk(clk), .en(en), .sample_time(sample_time),
		.mid(start_q), .rate(rise_q), .logit(l_rise)
	);

	dlc_edge #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_fall (
		.clk(clk), .en(en), .sample_time(sample_time),
		.mid(end_q), .rate(fall_q), .logit(l_fall)
	);

	// tail: shape s, scale by span, round, offset and clamp
	logic signed [17:0] s_s24;
	logic signed [34:0] prod_s25;
	logic signed [16:0] span;
	logic signed [35:0] rnd;
	logic signed [20:0] res;

	always_comb begin
		span = $signed({max_q[15], max_q}) - $signed({min_q[15], min_q});
		rnd  = 36'(prod_s25) + 36'sd32768;
		res  = 21'(rnd >>> 16) + 21'($signed(min_q));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s24    <= $signed({1'b0, l_rise}) - $signed({1'b0, l_fall});
			prod_s25 <= span * s_s24;
			if (res > 21'sd32767)
				curve_value <= 16'sh7FFF;
			else if (res < -21'sd32768)
				curve_value <= -16'sh8000;
			else
				curve_value <= res[15:0];
			params_invalid <= end_q < start_q;
		end
	end

endmodule
